>>> sv/lwbc_pkg.sv
// shared types and constants of the lru write-back block cache
package lwbc_pkg;

   // number of cache slots and the widths that follow from it
   localparam int CAPACITY = 16;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths fixed by the interface
   localparam int BLOCK_W    = 32;
   localparam int COUNTER_W  = 32;
   localparam int FUNC_W     = 2;
   localparam int KIND_W     = 2;
   localparam int RSP_SLOT_W = 4;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

   // result kind codes
   localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FETCH     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FLUSHED   = 2'd3;

   // decoded operation held in the request queue
   typedef enum logic [1:0] {
      OP_READ,
      OP_WRITE,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [BLOCK_W-1:0] block;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [BLOCK_W-1:0]    target_block;
      logic [RSP_SLOT_W-1:0] slot;
      logic                  hit;
      logic [COUNTER_W-1:0]  hits_total;
      logic [COUNTER_W-1:0]  misses_total;
      logic                  last;
   } rsp_type;

endpackage

>>> sv/lwbc_front.sv
// request front end: decodes incoming items and queues them for the engine
module lwbc_front
   import lwbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [FUNC_W-1:0]  func,
   input  logic [BLOCK_W-1:0] block_number,
   output logic               full,
   output logic               head_valid,
   output req_type            head,
   input  logic               pop
);

   req_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       keep;
   req_type    item;

   // classify the function; an unknown code is taken and dropped
   always_comb begin
      keep       = 1'b1;
      item.block = block_number;
      unique case (func)
         FUNC_READ:  item.op = OP_READ;
         FUNC_WRITE: item.op = OP_WRITE;
         FUNC_FLUSH: item.op = OP_FLUSH;
         default: begin
            item.op = OP_READ;
            keep    = 1'b0;
         end
      endcase
   end

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = mem_ff[rd_ptr_ff];

   // two-entry queue pointers
   always_comb begin
      logic wr_en;
      logic rd_en;
      wr_en     = push && !full && keep;
      rd_en     = pop && head_valid;
      wr_ptr_in = wr_en ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push && !full && keep) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

>>> sv/lwbc_rsp_queue.sv
// result queue between the engine and the result port
module lwbc_rsp_queue
   import lwbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type item,
   output logic    full,
   output logic    empty,
   output rsp_type head,
   input  logic    pop
);

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       wr_en;
   logic       rd_en;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];
   assign wr_en = push && !full;
   assign rd_en = pop && !empty;

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_en ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, wr_en} - {1'b0, rd_en};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

>>> sv/lwbc_engine.sv
// tag, dirty, lru and counter engine that carries out one item at a time
module lwbc_engine
   import lwbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_head,
   output logic    req_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_item
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_WB,
      ST_FETCH,
      ST_DONE,
      ST_SCAN,
      ST_FLUSHED
   } state_type;

   state_type            state_ff, state_in;
   logic [BLOCK_W-1:0]   tag_ff [CAPACITY];
   logic [BLOCK_W-1:0]   tag_in [CAPACITY];
   logic [SLOT_W-1:0]    rank_ff [CAPACITY];
   logic [SLOT_W-1:0]    rank_in [CAPACITY];
   logic [CAPACITY-1:0]  dirty_ff, dirty_in;
   logic [CAPACITY-1:0]  match_ff, match_in;
   logic [CNT_W-1:0]     filled_ff, filled_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [COUNTER_W-1:0] hits_ff, hits_in;
   logic [COUNTER_W-1:0] misses_ff, misses_in;
   logic [BLOCK_W-1:0]   blk_ff, blk_in;
   logic [BLOCK_W-1:0]   wb_blk_ff, wb_blk_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 write_ff, write_in;
   logic                 hit_ff, hit_in;

   logic [CAPACITY-1:0]  valid;
   logic [CAPACITY-1:0]  zero_rank;
   logic [SLOT_W-1:0]    hit_idx;
   logic [SLOT_W-1:0]    victim_idx;
   logic [SLOT_W-1:0]    rd_addr;
   logic                 is_full;

   // which slots hold a block, and which of them is least recently used
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         valid[i]     = (CNT_W'(i) < filled_ff);
         zero_rank[i] = valid[i] && (rank_ff[i] == '0);
      end
   end

   // priority encoders for the matching slot and the victim slot
   always_comb begin
      hit_idx    = '0;
      victim_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_idx = SLOT_W'(i);
         end
         if (zero_rank[i]) begin
            victim_idx = SLOT_W'(i);
         end
      end
   end

   assign is_full = (filled_ff == CNT_W'(CAPACITY));
   // read address on the tag and dirty arrays: the scan slot during a flush, else the victim
   assign rd_addr = (state_ff == ST_SCAN) ? scan_ff[SLOT_W-1:0] : victim_idx;

   // next state and storage updates
   always_comb begin
      logic              touch;
      logic [SLOT_W-1:0] old_rank;
      logic [SLOT_W-1:0] s;
      logic              hit;

      state_in  = state_ff;
      tag_in    = tag_ff;
      rank_in   = rank_ff;
      dirty_in  = dirty_ff;
      match_in  = match_ff;
      filled_in = filled_ff;
      scan_in   = scan_ff;
      hits_in   = hits_ff;
      misses_in = misses_ff;
      blk_in    = blk_ff;
      wb_blk_in = wb_blk_ff;
      slot_in   = slot_ff;
      write_in  = write_ff;
      hit_in    = hit_ff;
      req_pop   = 1'b0;
      rsp_push  = 1'b0;
      touch     = 1'b0;
      old_rank  = '0;
      s         = '0;
      hit       = |match_ff;

      rsp_item              = '0;
      rsp_item.hits_total   = hits_ff;
      rsp_item.misses_total = misses_ff;
      rsp_item.target_block = blk_ff;
      rsp_item.slot         = RSP_SLOT_W'(slot_ff);

      unique case (state_ff)
         // take the next item and compare its block against all tags
         ST_IDLE: begin
            if (req_valid) begin
               req_pop  = 1'b1;
               blk_in   = req_head.block;
               write_in = (req_head.op == OP_WRITE);
               scan_in  = '0;
               for (int i = 0; i < CAPACITY; i++) begin
                  match_in[i] = valid[i] && (tag_ff[i] == req_head.block);
               end
               state_in = (req_head.op == OP_FLUSH) ? ST_SCAN : ST_LOOKUP;
            end
         end

         // hit, fill of a free slot, or eviction of the lru slot
         ST_LOOKUP: begin
            if (hit) begin
               s        = hit_idx;
               touch    = 1'b1;
               old_rank = rank_ff[hit_idx];
               hits_in  = hits_ff + 1'b1;
               dirty_in[s] = dirty_ff[s] | write_ff;
               state_in = ST_DONE;
            end else begin
               misses_in = misses_ff + 1'b1;
               if (!is_full) begin
                  s         = filled_ff[SLOT_W-1:0];
                  filled_in = CNT_W'(filled_ff + 1'b1);
                  state_in  = ST_FETCH;
               end else begin
                  s        = victim_idx;
                  touch    = 1'b1;
                  state_in = dirty_ff[rd_addr] ? ST_WB : ST_FETCH;
               end
               tag_in[s]   = blk_ff;
               dirty_in[s] = write_ff;
            end
            wb_blk_in = tag_ff[rd_addr];
            slot_in   = s;
            hit_in    = hit;
            if (touch) begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (valid[i] && (rank_ff[i] > old_rank)) begin
                     rank_in[i] = rank_ff[i] - 1'b1;
                  end
               end
            end
            rank_in[s] = SLOT_W'(filled_in - 1'b1);
         end

         ST_WB: begin
            rsp_push              = 1'b1;
            rsp_item.kind         = KIND_WRITEBACK;
            rsp_item.target_block = wb_blk_ff;
            if (!rsp_full) begin
               state_in = ST_FETCH;
            end
         end

         ST_FETCH: begin
            rsp_push      = 1'b1;
            rsp_item.kind = KIND_FETCH;
            if (!rsp_full) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            rsp_push      = 1'b1;
            rsp_item.kind = KIND_DONE;
            rsp_item.hit  = hit_ff;
            rsp_item.last = 1'b1;
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end

         // walk the filled slots, writing back each dirty one
         ST_SCAN: begin
            if (scan_ff >= filled_ff) begin
               state_in = ST_FLUSHED;
            end else if (dirty_ff[rd_addr]) begin
               rsp_push              = 1'b1;
               rsp_item.kind         = KIND_WRITEBACK;
               rsp_item.target_block = tag_ff[rd_addr];
               rsp_item.slot         = RSP_SLOT_W'(rd_addr);
               if (!rsp_full) begin
                  dirty_in[rd_addr] = 1'b0;
                  scan_in           = CNT_W'(scan_ff + 1'b1);
               end
            end else begin
               scan_in = CNT_W'(scan_ff + 1'b1);
            end
         end

         ST_FLUSHED: begin
            rsp_push              = 1'b1;
            rsp_item.kind         = KIND_FLUSHED;
            rsp_item.target_block = '0;
            rsp_item.slot         = '0;
            rsp_item.last         = 1'b1;
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         dirty_ff  <= '0;
         filled_ff <= '0;
         hits_ff   <= '0;
         misses_ff <= '0;
      end else begin
         state_ff  <= state_in;
         dirty_ff  <= dirty_in;
         filled_ff <= filled_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
      end
      tag_ff    <= tag_in;
      rank_ff   <= rank_in;
      match_ff  <= match_in;
      scan_ff   <= scan_in;
      blk_ff    <= blk_in;
      wb_blk_ff <= wb_blk_in;
      slot_ff   <= slot_in;
      write_ff  <= write_in;
      hit_ff    <= hit_in;
   end

   // fill count never runs past the number of slots
   assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   // tags among filled slots are unique, so at most one slot matches
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP) |-> $onehot0(match_ff))
      else $error("block found in more than one slot");

   // a full cache has exactly one least recently used slot
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && is_full) |-> $onehot(zero_rank))
      else $error("lru order broken");

   // a hit never changes the fill count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && (|match_ff)) |=> $stable(filled_ff))
      else $error("fill count moved on a hit");

   // after the flush walk no dirty mark is left
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSHED) |-> (dirty_ff == '0))
      else $error("dirty slot left after flush");

endmodule

>>> sv/lru_writeback_block_cache.sv
// top level of the lru write-back block cache tag and policy engine
// Each request is a read, a write or a flush of a fully associative, 16-slot
// write-back cache with lru replacement; only tags, dirty marks, lru order
// and hit/miss counters live here, the block data sits in an external store
// addressed by the slot number in each result. Requests enter a two-deep
// queue and results leave through another, so either side may stall. The
// engine carries out one item at a time and waits while results stall: a
// hit gives a done result, a miss a fetch then a done, a dirty eviction a
// write-back first, a flush a write-back per dirty slot and a flushed result.
// A function code of 3 is taken and dropped without any result.
module lru_writeback_block_cache
   import lwbc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [BLOCK_W-1:0]    req_block_number,
   output logic                  empty,
   input  logic                  pop,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [BLOCK_W-1:0]    rsp_target_block,
   output logic [RSP_SLOT_W-1:0] rsp_slot,
   output logic                  rsp_hit,
   output logic [COUNTER_W-1:0]  rsp_hits_total,
   output logic [COUNTER_W-1:0]  rsp_misses_total,
   output logic                  rsp_last
);

   logic    head_valid;
   req_type head;
   logic    head_pop;
   logic    rq_full;
   logic    rq_push;
   rsp_type rq_item;
   rsp_type rq_head;

   // decode and queue requests
   lwbc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .func         (req_func),
      .block_number (req_block_number),
      .full         (full),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (head_pop)
   );

   // lookup, replacement and flush
   lwbc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (head_valid),
      .req_head  (head),
      .req_pop   (head_pop),
      .rsp_full  (rq_full),
      .rsp_push  (rq_push),
      .rsp_item  (rq_item)
   );

   // result queue
   lwbc_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rq_push),
      .item  (rq_item),
      .full  (rq_full),
      .empty (empty),
      .head  (rq_head),
      .pop   (pop)
   );

   assign rsp_kind         = rq_head.kind;
   assign rsp_target_block = rq_head.target_block;
   assign rsp_slot         = rq_head.slot;
   assign rsp_hit          = rq_head.hit;
   assign rsp_hits_total   = rq_head.hits_total;
   assign rsp_misses_total = rq_head.misses_total;
   assign rsp_last         = rq_head.last;

endmodule
